// File: design/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

   typedef logic [7:0] led_type;
   typedef logic [7:0] cmd_type;
   typedef logic [5:0] count_type;

   // pattern select codes (high nibble of the command, low nibble cleared)
   localparam cmd_type SEL_CHECKER = 8'h20;
   localparam cmd_type SEL_BOUNCE  = 8'h30;
   localparam cmd_type SEL_BLINK   = 8'h40;

   // speed codes (low nibble of the command); any other code keeps the limit
   localparam logic [3:0] SPD_LIMIT0  = 4'd1;
   localparam logic [3:0] SPD_LIMIT2  = 4'd2;
   localparam logic [3:0] SPD_LIMIT5  = 4'd3;
   localparam logic [3:0] SPD_LIMIT10 = 4'd4;
   localparam logic [3:0] SPD_LIMIT20 = 4'd5;
   localparam logic [3:0] SPD_LIMIT40 = 4'd6;

   localparam logic [1:0] PAT_SWAP    = 2'd0;
   localparam logic [1:0] PAT_CHECKER = 2'd1;
   localparam logic [1:0] PAT_BOUNCE  = 2'd2;
   localparam logic [1:0] PAT_BLINK   = 2'd3;

   localparam led_type SWAP_HI    = 8'hF0;
   localparam led_type SWAP_LO    = 8'h0F;
   localparam led_type CHECK_A    = 8'hAA;
   localparam led_type CHECK_B    = 8'h55;
   localparam led_type BLINK_ON   = 8'hFF;
   localparam led_type BLINK_OFF  = 8'h00;
   localparam led_type BOUNCE_TOP = 8'h80;
   localparam led_type BOUNCE_BOT = 8'h01;

   localparam count_type LIMIT_MAX = 6'd40;

   // per-tick control handed from the pipeline to the pattern core
   typedef struct packed {
      logic    step;
      cmd_type command;
   } tick_type;

   // returns {known, limit}; unknown speed codes keep the old limit
   function automatic logic [6:0] decode_speed(input logic [3:0] code);
      logic [6:0] res;
      res = 7'd0;
      case (code)
         SPD_LIMIT0:  res = {1'b1, 6'd0};
         SPD_LIMIT2:  res = {1'b1, 6'd2};
         SPD_LIMIT5:  res = {1'b1, 6'd5};
         SPD_LIMIT10: res = {1'b1, 6'd10};
         SPD_LIMIT20: res = {1'b1, 6'd20};
         SPD_LIMIT40: res = {1'b1, LIMIT_MAX};
         default:     res = 7'd0;
      endcase
      return res;
   endfunction

   function automatic logic [1:0] decode_pattern(input cmd_type cmd);
      logic [1:0] pat;
      pat = PAT_SWAP;
      case (cmd & 8'hF0)
         SEL_CHECKER: pat = PAT_CHECKER;
         SEL_BOUNCE:  pat = PAT_BOUNCE;
         SEL_BLINK:   pat = PAT_BLINK;
         default:     pat = PAT_SWAP;
      endcase
      return pat;
   endfunction

endpackage

// File: design/lps_core.sv
`timescale 1ns / 1ps

module lps_core
   import lps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  tick_type tick,
   output led_type  led_next
);

   count_type  period_limit_ff, period_limit_in;
   count_type  tick_count_ff,   tick_count_in;
   led_type    swap_ff,   swap_in;
   led_type    checker_ff, checker_in;
   led_type    bounce_ff, bounce_in;
   logic       downward_ff, downward_in;
   led_type    blink_ff,  blink_in;

   logic [6:0] speed;
   logic [1:0] pattern;
   logic       wrap;
   logic       dir;

   always_comb begin
      speed   = decode_speed(tick.command[3:0]);
      pattern = decode_pattern(tick.command);

      period_limit_in = speed[6] ? speed[5:0] : period_limit_ff;
      wrap            = (tick_count_ff >= period_limit_in);
      tick_count_in   = wrap ? 6'd0 : tick_count_ff + 6'd1;

      swap_in     = swap_ff;
      checker_in  = checker_ff;
      bounce_in   = bounce_ff;
      downward_in = downward_ff;
      blink_in    = blink_ff;

      // bounce direction flips at either end before the shift
      if (bounce_ff >= BOUNCE_TOP) begin
         dir = 1'b1;
      end else if (bounce_ff <= BOUNCE_BOT) begin
         dir = 1'b0;
      end else begin
         dir = downward_ff;
      end

      if (wrap) begin
         case (pattern)
            PAT_SWAP:    swap_in    = (swap_ff == SWAP_HI) ? SWAP_LO : SWAP_HI;
            PAT_CHECKER: checker_in = (checker_ff == CHECK_A) ? CHECK_B : CHECK_A;
            PAT_BOUNCE: begin
               downward_in = dir;
               bounce_in   = dir ? (bounce_ff >> 1) : (bounce_ff << 1);
            end
            default:     blink_in   = (blink_ff == BLINK_ON) ? BLINK_OFF : BLINK_ON;
         endcase
      end

      case (pattern)
         PAT_SWAP:    led_next = swap_in;
         PAT_CHECKER: led_next = checker_in;
         PAT_BOUNCE:  led_next = bounce_in;
         default:     led_next = blink_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_limit_ff <= '0;
         tick_count_ff   <= '0;
         swap_ff         <= 8'h00;
         checker_ff      <= 8'h00;
         bounce_ff       <= BOUNCE_BOT;
         downward_ff     <= 1'b0;
         blink_ff        <= BLINK_ON;
      end else if (tick.step) begin
         period_limit_ff <= period_limit_in;
         tick_count_ff   <= tick_count_in;
         swap_ff         <= swap_in;
         checker_ff      <= checker_in;
         bounce_ff       <= bounce_in;
         downward_ff     <= downward_in;
         blink_ff        <= blink_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      tick_count_ff <= LIMIT_MAX)
      else $error("tick counter beyond largest period");

   a_bounce_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(bounce_ff))
      else $error("bounce pattern lost its single bit");

   a_swap_values: assert property (@(posedge clock) disable iff (reset)
      swap_ff == 8'h00 || swap_ff == SWAP_HI || swap_ff == SWAP_LO)
      else $error("nibble swap pattern corrupted");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !tick.step |=> $stable(tick_count_ff) && $stable(bounce_ff))
      else $error("state moved without a tick");

endmodule

// File: design/led_pattern_sequencer.sv
`timescale 1ns / 1ps
// channel   dir  payload                      handshake
// req_*     in   tdata[7:0] = command_byte    tvalid / tready
// rsp_*     out  tdata[7:0] = led_byte        tvalid / tready
//
// Two register stages: the command is captured in an input register, then the
// pattern core updates its state on the edge that loads the result register.
// Sustained rate is one tick per clock unless the result side stalls.
// The input stage keeps accepting while a result waits downstream, so one
// more tick can be buffered during an output stall before req_tready drops.
// Synchronous active-high reset empties both stages and restores the pattern
// state (limit 0, counter 0, bounce at 0x01 moving up, blink at 0xFF).
module led_pattern_sequencer
   import lps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] command_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] led_byte
);

   logic     in_valid_ff, in_valid_in;
   cmd_type  cmd_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   led_type  rsp_data_ff;
   led_type  led_next;
   logic     move;
   tick_type tick;

   // a transaction moves from the input stage into the result register
   assign move       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;

   assign tick.step    = move;
   assign tick.command = cmd_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tdata;
      end
      if (move) begin
         rsp_data_ff <= led_next;
      end
   end

   lps_core u_core (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .led_next (led_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_move_loads: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("result register not loaded after a step");

   a_no_step_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !tick.step)
      else $error("pattern core stepped without a command");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |=> $stable(cmd_ff))
      else $error("buffered command overwritten during a stall");

endmodule

// File: verif/led_pattern_sequencer_test.sv
`timescale 1ns / 1ps

module led_pattern_sequencer_test;
   import lps_pkg::*;

   // unknown speed codes (low nibble of the command), limit unchanged
   localparam logic [3:0] SPD_KEEP    = 4'd0;
   localparam logic [3:0] SPD_KEEP_HI = 4'hF;   // top unknown code

   // pattern one is picked by any high nibble outside the three select codes
   localparam cmd_type SEL_SWAP  = 8'h00;
   localparam cmd_type SEL_OTHER = 8'hF0;

   localparam int RANDOM_TICKS = 1030;
   localparam int PAUSE_AT     = 500;   // sender drains the pipe once here

   typedef struct packed {
      cmd_type cmd;
      logic    fixed;   // led value typed in below, else taken from the predictor
      led_type led;
   } tick_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] command_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] led_byte

   // predictor state
   count_type tick_limit;
   count_type tick_count;
   led_type   swap_leds;
   led_type   checker_leds;
   led_type   bounce_leds;
   logic      bounce_down;
   led_type   blink_leds;

   led_type      led_expect_q[$];
   tick_row_type tick_table[$];
   bit           idle_on = 1'b0;   // both sides insert random gaps while set
   int           error_count = 0;
   int           ticks_sent = 0;

   led_pattern_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One timer tick: speed decode, shared counter, selected pattern step.
   function automatic led_type predict_led(input cmd_type cmd);
      logic [1:0] pat;
      cmd_type    sel;
      sel = cmd & 8'hF0;
      case (cmd[3:0])
         SPD_LIMIT0:  tick_limit = 6'd0;
         SPD_LIMIT2:  tick_limit = 6'd2;
         SPD_LIMIT5:  tick_limit = 6'd5;
         SPD_LIMIT10: tick_limit = 6'd10;
         SPD_LIMIT20: tick_limit = 6'd20;
         SPD_LIMIT40: tick_limit = LIMIT_MAX;
         default: ;   // unknown code keeps the limit
      endcase
      if (sel == SEL_CHECKER)
         pat = PAT_CHECKER;
      else if (sel == SEL_BOUNCE)
         pat = PAT_BOUNCE;
      else if (sel == SEL_BLINK)
         pat = PAT_BLINK;
      else
         pat = PAT_SWAP;

      // >= so a lowered limit fires on the tick that lowers it
      if (tick_count >= tick_limit) begin
         tick_count = '0;
         case (pat)
            PAT_SWAP:    swap_leds = (swap_leds == SWAP_HI) ? SWAP_LO : SWAP_HI;
            PAT_CHECKER: checker_leds = (checker_leds == CHECK_A) ? CHECK_B : CHECK_A;
            PAT_BOUNCE: begin
               if (bounce_leds >= BOUNCE_TOP)
                  bounce_down = 1'b1;
               else if (bounce_leds <= BOUNCE_BOT)
                  bounce_down = 1'b0;
               bounce_leds = bounce_down ? (bounce_leds >> 1) : (bounce_leds << 1);
            end
            default:     blink_leds = (blink_leds == BLINK_ON) ? BLINK_OFF : BLINK_ON;
         endcase
      end else begin
         tick_count = tick_count + 6'd1;
      end

      case (pat)
         PAT_SWAP:    return swap_leds;
         PAT_CHECKER: return checker_leds;
         PAT_BOUNCE:  return bounce_leds;
         default:     return blink_leds;
      endcase
   endfunction

   function automatic void add_tick(input cmd_type cmd, input logic fixed,
                                    input led_type led);
      tick_row_type row;
      row.cmd = cmd;
      row.fixed = fixed;
      row.led = led;
      tick_table.push_back(row);
   endfunction

   function automatic cmd_type pick_select();
      case ($urandom_range(0, 4))
         0: return SEL_SWAP;
         1: return SEL_CHECKER;
         2: return SEL_BOUNCE;
         3: return SEL_BLINK;
         default: return {4'($urandom_range(0, 15)), 4'h0};
      endcase
   endfunction

   function automatic logic [3:0] pick_keep_code();
      if ($urandom_range(0, 1) == 0)
         return SPD_KEEP;
      return 4'($urandom_range(7, 15));
   endfunction

   // Drives one command transaction and records its expected led byte at
   // the accepting edge. valid stays high across back-to-back transactions.
   task automatic send_tick(input cmd_type cmd, input logic fixed, input led_type led);
      int      gap;
      led_type predicted;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_led(cmd);
      led_expect_q.push_back(fixed ? led : predicted);
      ticks_sent++;
   endtask

   // Result side: random stall per transaction, compare against the oldest
   // expectation. Signals are read right after the edge, i.e. pre-edge values.
   initial begin : led_drain
      int      stall;
      led_type want;
      wait (!reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (led_expect_q.size() == 0) begin
            $error("led_byte: no transaction pending, got %h", rsp_tdata);
            error_count++;
         end else begin
            want = led_expect_q.pop_front();
            if (rsp_tdata !== want) begin
               $error("led_byte: expected %h, got %h", want, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int       run_len;
      int       roll;
      cmd_type  run_sel;
      logic [3:0] run_speed;
      cmd_type  cmd;
      bit       paused;

      paused = 1'b0;

      // predictor reset state
      tick_limit = '0;
      tick_count = '0;
      swap_leds = 8'h00;
      checker_leds = 8'h00;
      bounce_leds = BOUNCE_BOT;
      bounce_down = 1'b0;
      blink_leds = BLINK_ON;

      // directed ticks; fixed values hold with limit 0 (every tick steps)
      add_tick(SEL_SWAP | SPD_LIMIT0, 1'b1, SWAP_HI);
      add_tick(SEL_CHECKER | SPD_LIMIT0, 1'b1, CHECK_A);
      add_tick(SEL_BOUNCE | SPD_LIMIT0, 1'b1, 8'h02);
      add_tick(SEL_BLINK | SPD_LIMIT0, 1'b1, BLINK_OFF);
      add_tick(SEL_OTHER | SPD_KEEP_HI, 1'b1, SWAP_LO);   // all ones: pattern one
      add_tick(SEL_SWAP | SPD_KEEP, 1'b1, SWAP_HI);       // all zeros
      // bounce walks up to the top bit, then turns around
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, 8'h04);
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, 8'h08);
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, 8'h10);
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, 8'h20);
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, 8'h40);
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, BOUNCE_TOP);
      add_tick(SEL_BOUNCE | SPD_KEEP, 1'b1, 8'h40);
      // slow limit, pattern change mid count, then limit dropped below counter
      add_tick(SEL_CHECKER | SPD_LIMIT40, 1'b0, '0);
      add_tick(SEL_BLINK | SPD_LIMIT40, 1'b0, '0);
      add_tick(SEL_BLINK | SPD_LIMIT40, 1'b0, '0);
      add_tick(SEL_BLINK | SPD_LIMIT2, 1'b0, '0);
      add_tick(8'h50 | SPD_KEEP, 1'b0, '0);
      add_tick(8'hE0 | SPD_LIMIT20, 1'b0, '0);
      add_tick(SEL_BOUNCE | SPD_LIMIT5, 1'b0, '0);
      add_tick(SEL_CHECKER | SPD_LIMIT10, 1'b0, '0);
      add_tick(8'h90 | 4'hA, 1'b0, '0);
      add_tick(SEL_BLINK | 4'h8, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (tick_table[i])
         send_tick(tick_table[i].cmd, tick_table[i].fixed, tick_table[i].led);

      // Random part: mostly runs of one speed and pattern so the counter
      // reaches even the slowest limit, with stray speed codes, pattern
      // switches and fully random bytes mixed in.
      while (ticks_sent < tick_table.size() + RANDOM_TICKS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (!paused && ticks_sent >= PAUSE_AT) begin
            // hold off until the pipe has drained completely
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (led_expect_q.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 10))
               send_tick(8'($urandom_range(0, 255)), 1'b0, '0);
         end else begin
            run_sel = pick_select();
            run_speed = 4'($urandom_range(1, 6));
            run_len = $urandom_range(1, 60);
            repeat (run_len) begin
               roll = $urandom_range(0, 99);
               cmd = run_sel | run_speed;
               if (roll < 8)
                  cmd = 8'($urandom_range(0, 255));
               else if (roll < 20)
                  cmd = run_sel | pick_keep_code();
               else if (roll < 30)
                  cmd = pick_select() | run_speed;
               send_tick(cmd, 1'b0, '0);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (led_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
